// ===== hw/rtl/gpa_pkg.sv =====
// Shared types, constants and helpers for the grouped product aggregator.
// No dependencies; every other file imports this package.
`default_nettype none

package gpa_pkg;

   localparam int GROUP_W        = 10;
   localparam int VALUE_W        = 64;
   localparam int NUM_GROUPS_DEF = 1024;
   localparam int RSP_DEPTH      = 16;
   localparam int CSR_AW         = 3;
   localparam int CSR_DW         = 32;

   localparam logic       KIND_ACC     = 1'b0;
   localparam logic       KIND_READ    = 1'b1;
   localparam logic       CSR_SKIP_IDX = 1'b0;
   localparam logic [10:0] EXP_MAX     = 11'h7FF;

   localparam logic [VALUE_W-1:0] NA_BITS   = 64'h7FF0_0000_0000_07A2;
   localparam logic [VALUE_W-1:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
   localparam logic [VALUE_W-1:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;

   // Per-stage control and bypass data of one word in the update pipeline
   typedef struct packed {
      logic               valid;
      logic               kind;
      logic [GROUP_W-1:0] group;
      logic               wr_en;
      logic               touched_new;
      logic               use_mul;
      logic               sign;
      logic [VALUE_W-1:0] byp;
   } meta_type;

   typedef struct packed {
      logic [GROUP_W-1:0] out_group;
      logic [VALUE_W-1:0] product;
   } rsp_word_type;

   function automatic logic is_nan(input logic [VALUE_W-1:0] b);
      return (b[62:52] == EXP_MAX) && (b[51:0] != 52'b0);
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gpa_if.sv =====
// Valid/ready channel interfaces for request and response words.
// Depends on gpa_pkg for field widths.
`default_nettype none

interface gpa_req_if;
   import gpa_pkg::*;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [GROUP_W-1:0] group;
   logic [VALUE_W-1:0] value;
   modport source (output valid, kind, group, value, input ready);
   modport sink   (input valid, kind, group, value, output ready);
endinterface

interface gpa_rsp_if;
   import gpa_pkg::*;
   logic               valid;
   logic               ready;
   logic [GROUP_W-1:0] out_group;
   logic [VALUE_W-1:0] product;
   modport source (output valid, out_group, product, input ready);
   modport sink   (input valid, out_group, product, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gpa_fmul.sv =====
// Five-stage double-precision significand multiplier with round-to-nearest-even.
// Operands are finite and nonzero; sign and special values are handled outside. Uses gpa_pkg.
`default_nettype none

module gpa_fmul (
   input  wire logic        clock,
   input  wire logic [52:0] ma,
   input  wire logic [52:0] mb,
   input  wire logic [11:0] esum,
   output logic      [62:0] mag
);
   import gpa_pkg::*;

   function automatic logic [6:0] lzc106(input logic [105:0] p);
      logic [6:0] n;
      n = 7'd106;
      for (int i = 0; i < 106; i++) begin
         if (p[i]) n = 7'(105 - i);
      end
      return n;
   endfunction

   logic [51:0]  hh_ff;
   logic [52:0]  hl_ff, lh_ff;
   logic [53:0]  ll_ff;
   logic [11:0]  e1_ff, e2_ff;
   logic [105:0] p_ff, p3_ff, pn_ff;
   logic [6:0]   lz_ff;
   logic signed [13:0] e3_ff, e4_ff;
   logic [52:0]  m_ff;
   logic         g_ff, st_ff, ovf_ff;
   logic [10:0]  ef_ff;

   logic [105:0] mid;
   logic [13:0]  sh_wide;
   logic [6:0]   sh;
   logic [211:0] x;
   logic         rnd;
   logic [62:0]  body;

   always_comb begin
      mid     = 106'(hl_ff) + 106'(lh_ff);
      sh_wide = 14'(14'sd1 - e4_ff);
      if (e4_ff >= 14'sd1) begin
         sh = 7'd0;
      end else if (sh_wide > 14'd127) begin
         sh = 7'd127;
      end else begin
         sh = sh_wide[6:0];
      end
      x    = {pn_ff, 106'b0} >> sh;
      rnd  = g_ff & (st_ff | m_ff[0]);
      body = {ef_ff, m_ff[51:0]} + 63'(rnd);
      mag  = ovf_ff ? {EXP_MAX, 52'b0} : body;
   end

   always_ff @(posedge clock) begin
      hh_ff <= ma[52:27] * mb[52:27];
      hl_ff <= ma[52:27] * mb[26:0];
      lh_ff <= ma[26:0] * mb[52:27];
      ll_ff <= ma[26:0] * mb[26:0];
      e1_ff <= esum;

      p_ff  <= {hh_ff, 54'b0} + (mid << 27) + 106'(ll_ff);
      e2_ff <= e1_ff;

      lz_ff <= lzc106(p_ff);
      p3_ff <= p_ff;
      e3_ff <= $signed({2'b0, e2_ff}) - 14'sd1022 - $signed({7'b0, lzc106(p_ff)});

      pn_ff <= p3_ff << lz_ff;
      e4_ff <= e3_ff;

      // denormalize by shifting right when the exponent underflows
      m_ff   <= x[211:159];
      g_ff   <= x[158];
      st_ff  <= |x[157:0];
      ef_ff  <= (e4_ff >= 14'sd1) ? e4_ff[10:0] : 11'd0;
      ovf_ff <= (e4_ff >= 14'sd2047);
   end

endmodule

`default_nettype wire

// ===== hw/rtl/gpa_rsp_fifo.sv =====
// Response queue between the update pipeline and the response channel.
// Uses gpa_pkg for the word type.
`default_nettype none

module gpa_rsp_fifo #(
   parameter int DEPTH = gpa_pkg::RSP_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire gpa_pkg::rsp_word_type push_word,
   input  wire logic                  pop,
   output logic                       out_valid,
   output gpa_pkg::rsp_word_type      out_word,
   output logic [$clog2(DEPTH):0]     count
);
   import gpa_pkg::*;

   localparam int PW = $clog2(DEPTH);

   rsp_word_type   buf_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PW:0]    cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
      out_valid = (cnt_ff != '0);
      out_word  = buf_ff[rd_ptr_ff];
      count     = cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) buf_ff[wr_ptr_ff] <= push_word;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/grouped_product_aggregator_core.sv =====
// Top level of the grouped product aggregator: group memory, update pipeline, CSR.
// Depends on gpa_pkg, gpa_if, gpa_fmul and gpa_rsp_fifo.
//
//   channel | dir | handshake              | word
//   req     | in  | valid/ready            | kind, group, value
//   rsp     | out | valid/ready            | out_group, product
//   csr     | in  | APB psel/penable/pready| skip_missing at offset 0
//
// One word per cycle is accepted while req.ready is high; a read word reaches rsp through the stage-1
// registers, the meta pipeline and the response queue. A word whose group is still in the 7-stage
// read/multiply/write-back path waits, so back-to-back words of one group never overlap in that path.
// After reset a clearing pass writes zero to every group before any word is taken.
// A 16-word response queue absorbs rsp stalls; req backs off when queued and in-flight reads would overflow it.
`default_nettype none

module grouped_product_aggregator_core #(
   parameter int NUM_GROUPS = gpa_pkg::NUM_GROUPS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   gpa_req_if.sink                          req,
   gpa_rsp_if.source                        rsp,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [gpa_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [gpa_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic      [gpa_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import gpa_pkg::*;

   localparam int AW  = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int NST = 6;
   localparam int QW  = $clog2(RSP_DEPTH);

   // ---------------- configuration ----------------
   logic skip_ff, skip_in;
   logic csr_wr;

   always_comb begin
      csr_wr     = csr_psel & csr_penable & csr_pwrite;
      csr_pready = 1'b1;
      skip_in    = skip_ff;
      if (csr_wr && csr_paddr[CSR_AW-1] == CSR_SKIP_IDX) skip_in = csr_pwdata[0];
      csr_prdata = (csr_paddr[CSR_AW-1] == CSR_SKIP_IDX) ? {{(CSR_DW-1){1'b0}}, skip_ff}
                                                         : '0;
   end

   // ---------------- storage ----------------
   logic [VALUE_W:0] mem [NUM_GROUPS];
   logic [VALUE_W:0] rd_ff;
   logic             wen;
   logic [AW-1:0]    waddr;
   logic [VALUE_W:0] wdata;

   logic          clr_active_ff, clr_active_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;

   // ---------------- pipeline ----------------
   logic               s1_valid_ff;
   logic               s1_kind_ff;
   logic [GROUP_W-1:0] s1_group_ff;
   logic [VALUE_W-1:0] s1_value_ff;
   meta_type           meta_ff [NST];
   meta_type           meta_in;
   logic [52:0]        ma_ff, ma_in, mb_ff, mb_in;
   logic [11:0]        esum_ff, esum_in;
   logic [62:0]        mul_mag;

   logic               accept, hazard, credit_ok;
   logic [2:0]         rd_cnt;
   logic [QW:0]        fifo_cnt;
   logic               push, pop, fifo_valid;
   rsp_word_type       push_word, fifo_word;
   meta_type           last;
   logic [VALUE_W-1:0] result;

   // decision stage terms
   logic               s1_range, touched, eff_nan, val_nan, need_mul;
   logic [VALUE_W-1:0] eff;
   logic [10:0]        a_exp, b_exp;
   logic               a_zero, b_zero, a_inf, b_inf;

   always_comb begin
      hazard = s1_valid_ff && (s1_group_ff == req.group);
      rd_cnt = 3'(s1_valid_ff && s1_kind_ff == KIND_READ);
      for (int i = 0; i < NST; i++) begin
         if (meta_ff[i].valid && meta_ff[i].group == req.group) hazard = 1'b1;
         rd_cnt = rd_cnt + 3'(meta_ff[i].valid && meta_ff[i].kind == KIND_READ);
      end
      credit_ok = (6'(fifo_cnt) + 6'(rd_cnt)) < 6'(RSP_DEPTH);
      req.ready = !clr_active_ff && !hazard && credit_ok;
      accept    = req.valid && req.ready;
   end

   always_comb begin
      s1_range = 32'(s1_group_ff) < 32'(NUM_GROUPS);
      touched  = rd_ff[VALUE_W];
      eff      = (s1_range && touched) ? rd_ff[VALUE_W-1:0]
                                       : (skip_ff ? NA_BITS : ONE_BITS);
      eff_nan  = is_nan(eff);
      val_nan  = is_nan(s1_value_ff);
      a_exp    = eff[62:52];
      b_exp    = s1_value_ff[62:52];
      a_zero   = (a_exp == 11'd0) && (eff[51:0] == 52'b0);
      b_zero   = (b_exp == 11'd0) && (s1_value_ff[51:0] == 52'b0);
      a_inf    = (a_exp == EXP_MAX);
      b_inf    = (b_exp == EXP_MAX);
      need_mul = 1'b0;

      meta_in             = '0;
      meta_in.valid       = s1_valid_ff;
      meta_in.kind        = s1_kind_ff;
      meta_in.group       = s1_group_ff;
      meta_in.sign        = eff[63] ^ s1_value_ff[63];
      meta_in.byp         = eff;

      if (s1_kind_ff == KIND_READ) begin
         meta_in.wr_en = s1_range;
      end else if (s1_range) begin
         if (skip_ff) begin
            if (!val_nan) begin
               meta_in.wr_en       = 1'b1;
               meta_in.touched_new = 1'b1;
               if (eff_nan) meta_in.byp = s1_value_ff;
               else         need_mul    = 1'b1;
            end
         end else begin
            meta_in.wr_en       = 1'b1;
            meta_in.touched_new = 1'b1;
            if (!eff_nan) begin
               if (val_nan) meta_in.byp = s1_value_ff;
               else         need_mul    = 1'b1;
            end
         end
      end

      if (need_mul) begin
         if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            meta_in.byp = QNAN_BITS;
         end else if (a_inf || b_inf) begin
            meta_in.byp = {meta_in.sign, EXP_MAX, 52'b0};
         end else if (a_zero || b_zero) begin
            meta_in.byp = {meta_in.sign, 63'b0};
         end else begin
            meta_in.use_mul = 1'b1;
         end
      end

      ma_in   = {a_exp != 11'd0, eff[51:0]};
      mb_in   = {b_exp != 11'd0, s1_value_ff[51:0]};
      esum_in = 12'((a_exp == 11'd0) ? 11'd1 : a_exp) + 12'((b_exp == 11'd0) ? 11'd1 : b_exp);
   end

   gpa_fmul u_fmul (
      .clock (clock),
      .ma    (ma_ff),
      .mb    (mb_ff),
      .esum  (esum_ff),
      .mag   (mul_mag)
   );

   // ---------------- write-back and response ----------------
   always_comb begin
      last          = meta_ff[NST-1];
      result        = last.use_mul ? {last.sign, mul_mag} : last.byp;
      wen           = clr_active_ff | (last.valid & last.wr_en);
      waddr         = clr_active_ff ? clr_cnt_ff : AW'(last.group);
      wdata         = clr_active_ff ? '0 : {last.touched_new, result};
      push          = last.valid && last.kind == KIND_READ;
      push_word     = '{out_group: last.group, product: last.byp};
      pop           = fifo_valid && rsp.ready;
      rsp.valid     = fifo_valid;
      rsp.out_group = fifo_word.out_group;
      rsp.product   = fifo_word.product;

      clr_active_in = clr_active_ff;
      clr_cnt_in    = clr_cnt_ff;
      if (clr_active_ff) begin
         if (clr_cnt_ff == AW'(NUM_GROUPS - 1)) clr_active_in = 1'b0;
         else                                   clr_cnt_in    = clr_cnt_ff + 1'b1;
      end
   end

   gpa_rsp_fifo #(.DEPTH(RSP_DEPTH)) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .out_valid (fifo_valid),
      .out_word  (fifo_word),
      .count     (fifo_cnt)
   );

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff       <= 1'b1;
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         for (int i = 0; i < NST; i++) meta_ff[i].valid <= 1'b0;
      end else begin
         skip_ff       <= skip_in;
         clr_active_ff <= clr_active_in;
         clr_cnt_ff    <= clr_cnt_in;
         s1_valid_ff   <= accept;
         meta_ff[0]    <= meta_in;
         for (int i = 1; i < NST; i++) meta_ff[i] <= meta_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff  <= req.kind;
      s1_group_ff <= req.group;
      s1_value_ff <= req.value;
      ma_ff       <= ma_in;
      mb_ff       <= mb_in;
      esum_ff     <= esum_in;
   end

   always_ff @(posedge clock) begin
      if (wen) mem[waddr] <= wdata;
      if (accept) rd_ff <= mem[AW'(req.group)];
   end

   // ---------------- assertions ----------------
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      accept |-> !clr_active_ff)
      else $error("word accepted during clearing pass");

   a_no_same_group_overlap: assert property (@(posedge clock) disable iff (reset)
      accept |-> !(s1_valid_ff && s1_group_ff == req.group))
      else $error("word accepted while its group is in flight");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      push |-> (fifo_cnt < (QW+1)'(RSP_DEPTH)) || pop)
      else $error("response queue overflow");

   a_writeback_after_clear: assert property (@(posedge clock) disable iff (reset)
      meta_ff[NST-1].valid |-> !clr_active_ff)
      else $error("write-back during clearing pass");

endmodule

`default_nettype wire
